[hdl/gemm_alpha_beta_transpose_defines.svh]
// Assertion helpers shared by the gemm block.
`ifndef GEMM_ALPHA_BETA_TRANSPOSE_DEFINES_SVH
`define GEMM_ALPHA_BETA_TRANSPOSE_DEFINES_SVH

// Check a property while out of reset.
`define GAB_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("gemm check failed");

// Check a property at every edge, reset included.
`define GAB_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("gemm check failed");

`endif

[hdl/gemm_abt_pkg.sv]
`default_nettype none
package gemm_abt_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DIM_W       = 4;
   localparam int IDX_W       = 3;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int DATA_W      = 32;
   localparam int Q_FRAC      = 16;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_LOAD_C = 2'd2,
      CMD_START  = 2'd3
   } cmd_type;

   localparam logic [2:0] CMODE_NONE   = 3'd0;
   localparam logic [2:0] CMODE_SCALAR = 3'd1;
   localparam logic [2:0] CMODE_ROW    = 3'd2;
   localparam logic [2:0] CMODE_COL    = 3'd3;
   localparam logic [2:0] CMODE_FULL   = 3'd4;

   localparam logic [2:0] REG_TRANS_A = 3'd0;
   localparam logic [2:0] REG_TRANS_B = 3'd1;
   localparam logic [2:0] REG_ROWS_M  = 3'd2;
   localparam logic [2:0] REG_COLS_N  = 3'd3;
   localparam logic [2:0] REG_INNER_K = 3'd4;
   localparam logic [2:0] REG_ALPHA   = 3'd5;
   localparam logic [2:0] REG_BETA    = 3'd6;
   localparam logic [2:0] REG_C_MODE  = 3'd7;

   typedef struct packed {
      logic              trans_a;
      logic              trans_b;
      logic [DIM_W-1:0]  dim_m;
      logic [DIM_W-1:0]  dim_n;
      logic [DIM_W-1:0]  dim_k;
      logic [DATA_W-1:0] alpha;
      logic [DATA_W-1:0] beta;
      logic [2:0]        c_mode;
   } cfg_type;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic             first;
      logic             mul_en;
      logic             sum_en;
      logic             rnd_en;
      logic             out_en;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] step;
   } dp_cmd_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/gemm_alpha_beta_transpose.sv]
`default_nettype none
// Integer GEMM: Y = alpha * op(A) * op(B) + beta * C, alpha and beta Q16.16.
// Request channel (req_): one word per command. tuser carries the command
// (load A, load B, load C, start); tdata carries the store index and value.
// A load word is taken while idle and writes one store entry, no response.
// A start word runs the whole product and sends m*n response words (rsp_),
// row-major, tlast on the final one. Each result takes k operand reads from
// the A and B stores (one single-port read per cycle), a multiply-accumulate
// drain (WAIT1, WAIT2), scaling, rounding and saturation (MUL, SUM, RND,
// SAT), then the output register (SEND). No request is taken while a start
// runs; a stalled receiver holds the result in the output register and the
// sequencer waits. Configuration (csr_) is always ready and must be written
// while idle. Reset returns the registers to their defaults and the
// sequencer to idle; store contents are undefined until loaded.
module gemm_alpha_beta_transpose
   import gemm_abt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [1:0]  req_tuser,   // command
   input  wire logic [39:0] req_tdata,   // elem_index[5:0], elem_value[37:6], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // result_value[31:0], result_row[34:32],
                                         // result_col[37:35], zero pad
   output      logic        rsp_tlast,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type           cfg;
   dp_cmd_type        cmd;
   logic [DATA_W-1:0] out_value;
   logic [IDX_W-1:0]  out_row, out_col;

   gemm_abt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequence rows, columns and inner steps
   gemm_abt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_tvalid),
      .req_is_start (req_tuser == CMD_START),
      .req_ready    (req_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .cmd          (cmd)
   );

   // stores, multiply-accumulate, scaling and output register
   gemm_abt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .wr_sel    (req_tuser),
      .wr_addr   (req_tdata[5:0]),
      .wr_data   (req_tdata[37:6]),
      .out_value (out_value),
      .out_row   (out_row),
      .out_col   (out_col),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_col, out_row, out_value};

endmodule
`default_nettype wire

[hdl/gemm_abt_csr.sv]
`default_nettype none
module gemm_abt_csr
   import gemm_abt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [DATA_W-1:0] csr_data,
   output      cfg_type           cfg
);

   logic              trans_a_ff, trans_b_ff;
   logic [DIM_W-1:0]  m_ff, n_ff, k_ff;
   logic [DATA_W-1:0] alpha_ff, beta_ff;
   logic [2:0]        c_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_a_ff <= 1'b0;
         trans_b_ff <= 1'b0;
         m_ff       <= DIM_W'(MAX_DIM);
         n_ff       <= DIM_W'(MAX_DIM);
         k_ff       <= DIM_W'(MAX_DIM);
         alpha_ff   <= DATA_W'(32'h0001_0000);
         beta_ff    <= DATA_W'(32'h0001_0000);
         c_mode_ff  <= CMODE_NONE;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TRANS_A: trans_a_ff <= csr_data[0];
            REG_TRANS_B: trans_b_ff <= csr_data[0];
            REG_ROWS_M:  m_ff       <= csr_data[DIM_W-1:0];
            REG_COLS_N:  n_ff       <= csr_data[DIM_W-1:0];
            REG_INNER_K: k_ff       <= csr_data[DIM_W-1:0];
            REG_ALPHA:   alpha_ff   <= csr_data;
            REG_BETA:    beta_ff    <= csr_data;
            REG_C_MODE:  c_mode_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.trans_a = trans_a_ff;
      cfg.trans_b = trans_b_ff;
      cfg.dim_m   = clamp_dim(m_ff);
      cfg.dim_n   = clamp_dim(n_ff);
      cfg.dim_k   = clamp_dim(k_ff);
      cfg.alpha   = alpha_ff;
      cfg.beta    = beta_ff;
      cfg.c_mode  = c_mode_ff;
   end

endmodule
`default_nettype wire

[hdl/gemm_abt_dp.sv]
`default_nettype none
module gemm_abt_dp
   import gemm_abt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire dp_cmd_type        cmd,
   input  wire logic [1:0]        wr_sel,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output      logic [DATA_W-1:0] out_value,
   output      logic [IDX_W-1:0]  out_row,
   output      logic [IDX_W-1:0]  out_col,
   output      logic              out_last
);

   logic [DATA_W-1:0] a_mem [STORE_DEPTH];
   logic [DATA_W-1:0] b_mem [STORE_DEPTH];
   logic [DATA_W-1:0] c_mem [STORE_DEPTH];

   logic [DATA_W-1:0] a_q_ff, b_q_ff, c_q_ff;
   logic              v1_ff, f1_ff, v2_ff, f2_ff;
   logic [DATA_W-1:0] prod_ff, acc_ff;
   logic signed [63:0] p1_ff, p2_ff;
   logic signed [64:0] sum_ff;
   logic signed [48:0] q_ff;
   logic [DATA_W-1:0] val_ff;
   logic [IDX_W-1:0]  row_ff, col_ff;
   logic              last_ff;

   logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
   logic [2*DIM_W-1:0] row_k, step_m, col_k, step_n, row_n;
   logic              has_c;
   logic signed [64:0] sum_in;
   logic signed [64:0] bias;
   logic signed [48:0] q_in;
   logic [DATA_W-1:0] val_in;

   // linear addresses follow the stored layout of each operand
   always_comb begin
      row_k  = (2*DIM_W)'(cmd.row) * (2*DIM_W)'(cfg.dim_k);
      step_m = (2*DIM_W)'(cmd.step) * (2*DIM_W)'(cfg.dim_m);
      col_k  = (2*DIM_W)'(cmd.col) * (2*DIM_W)'(cfg.dim_k);
      step_n = (2*DIM_W)'(cmd.step) * (2*DIM_W)'(cfg.dim_n);
      row_n  = (2*DIM_W)'(cmd.row) * (2*DIM_W)'(cfg.dim_n);
      a_addr = cfg.trans_a ? ADDR_W'(step_m + (2*DIM_W)'(cmd.row))
                           : ADDR_W'(row_k + (2*DIM_W)'(cmd.step));
      b_addr = cfg.trans_b ? ADDR_W'(col_k + (2*DIM_W)'(cmd.step))
                           : ADDR_W'(step_n + (2*DIM_W)'(cmd.col));
      has_c  = 1'b1;
      case (cfg.c_mode)
         CMODE_SCALAR: c_addr = '0;
         CMODE_ROW:    c_addr = ADDR_W'(cmd.col);
         CMODE_COL:    c_addr = ADDR_W'(cmd.row);
         CMODE_FULL:   c_addr = ADDR_W'(row_n + (2*DIM_W)'(cmd.col));
         default: begin
            c_addr = '0;
            has_c  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         case (wr_sel)
            CMD_LOAD_A: a_mem[wr_addr] <= wr_data;
            CMD_LOAD_B: b_mem[wr_addr] <= wr_data;
            CMD_LOAD_C: c_mem[wr_addr] <= wr_data;
            default: ;
         endcase
      end
      if (cmd.rd_en) begin
         a_q_ff <= a_mem[a_addr];
         b_q_ff <= b_mem[b_addr];
         c_q_ff <= c_mem[c_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
      end
   end

   // sum of the alpha and beta products, rounding toward zero, saturation to int32
   always_comb begin
      sum_in = 65'(p1_ff) + 65'(p2_ff);
      bias   = sum_ff[64] ? 65'sd65535 : 65'sd0;
      q_in   = 49'((sum_ff + bias) >>> Q_FRAC);
      if (q_ff[48:31] == '0 || q_ff[48:31] == '1) val_in = q_ff[31:0];
      else if (q_ff[48]) val_in = 32'h8000_0000;
      else val_in = 32'h7FFF_FFFF;
   end

   always_ff @(posedge clock) begin
      f1_ff   <= cmd.first;
      f2_ff   <= f1_ff;
      prod_ff <= a_q_ff * b_q_ff;
      if (v2_ff) acc_ff <= f2_ff ? prod_ff : acc_ff + prod_ff;
      if (cmd.mul_en) begin
         p1_ff <= $signed(cfg.alpha) * $signed(acc_ff);
         p2_ff <= has_c ? $signed(cfg.beta) * $signed(c_q_ff) : 64'sd0;
      end
      if (cmd.sum_en) sum_ff <= sum_in;
      if (cmd.rnd_en) q_ff <= q_in;
      if (cmd.out_en) begin
         val_ff  <= val_in;
         row_ff  <= cmd.row;
         col_ff  <= cmd.col;
         last_ff <= cmd.last;
      end
   end

   assign out_value = val_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

[hdl/gemm_abt_ctrl.sv]
`default_nettype none
`include "gemm_alpha_beta_transpose_defines.svh"
module gemm_abt_ctrl
   import gemm_abt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   input  wire logic    req_is_start,
   output      logic    req_ready,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT1, ST_WAIT2, ST_MUL, ST_SUM, ST_RND, ST_SAT, ST_SEND
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, p_ff, p_in;
   logic             is_last;

   assign is_last = ({1'b0, i_ff} == cfg.dim_m - DIM_W'(1)) &&
                    ({1'b0, j_ff} == cfg.dim_n - DIM_W'(1));

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.row   = i_ff;
      cmd.col   = j_ff;
      cmd.step  = p_ff;
      cmd.last  = is_last;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_start) begin
                  i_in     = '0;
                  j_in     = '0;
                  p_in     = '0;
                  state_in = ST_ISSUE;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            cmd.first = (p_ff == '0);
            if ({1'b0, p_ff} == cfg.dim_k - DIM_W'(1)) begin
               p_in     = '0;
               state_in = ST_WAIT1;
            end else begin
               p_in = p_ff + IDX_W'(1);
            end
         end
         ST_WAIT1: state_in = ST_WAIT2;
         ST_WAIT2: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_RND;
         end
         ST_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            cmd.out_en = 1'b1;
            state_in   = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  if ({1'b0, j_ff} == cfg.dim_n - DIM_W'(1)) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         p_ff     <= p_in;
      end
   end

   `GAB_ASSERT(a_step_in_range, (state_ff == ST_ISSUE) |-> ({1'b0, p_ff} < cfg.dim_k))
   `GAB_ASSERT(a_sat_then_send, (state_ff == ST_SAT) |=> (state_ff == ST_SEND))
   `GAB_ASSERT(a_last_to_idle, (rsp_valid && rsp_ready && is_last) |=> (state_ff == ST_IDLE))
   `GAB_ASSERT_ALWAYS(a_no_overlap, !(req_ready && rsp_valid))

endmodule
`default_nettype wire

[tb/sv/tb_gemm_alpha_beta_transpose.sv]
`default_nettype none
module tb_gemm_alpha_beta_transpose;
   timeunit 1ns;
   timeprecision 1ps;
   import gemm_abt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 40;   // margin after each drain
   localparam int C_FILLED    = 16;   // C entries loaded before the first start

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
   } y_elem_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  idx;
      logic [31:0] val;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   gemm_alpha_beta_transpose uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Shadow of the block: stores and registers as the block should hold them.
   logic [31:0] a_mem [64];
   logic [31:0] b_mem [64];
   logic [31:0] c_mem [64];
   logic        sh_trans_a, sh_trans_b;
   logic [3:0]  sh_m, sh_n, sh_k;
   logic [31:0] sh_alpha, sh_beta;
   logic [2:0]  sh_c_mode;

   req_word_type pending_words[$];   // words waiting to be sent
   y_elem_type   expected_y[$];      // Y elements still owed by the block

   int  fails = 0;
   int  cycles = 0;
   int  words_sent = 0;
   int  starts_sent = 0;
   int  y_checked = 0;
   int  req_idle = 0;
   int  rsp_stall = 0;
   int  long_hold = 0;            // receiver hold-off, counted down below
   bit  calm = 1'b0;              // no idling in the closing stretch
   bit  req_taken = 1'b0;

   function automatic int eff_dim(logic [3:0] d);
      if (d == 4'd0) return 1;
      if (d > 4'd8) return 8;
      return int'(d);
   endfunction

   // alpha*dot + beta*c exactly, truncate toward zero, saturate to int32.
   function automatic logic [31:0] scale_q16(logic [31:0] dot, bit has_c, logic [31:0] cv);
      longint p1, p2;
      logic signed [65:0] s, q;
      p1 = longint'($signed(sh_alpha)) * longint'($signed(dot));
      p2 = has_c ? longint'($signed(sh_beta)) * longint'($signed(cv)) : 64'sd0;
      s = p1;
      s = s + p2;
      // beyond 64 bits: saturate toward the sign
      if (s[65:63] != 3'b000 && s[65:63] != 3'b111)
         return s[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      q = s / 66'sd65536;
      if (q > 66'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -66'sd2147483648) return 32'h8000_0000;
      return q[31:0];
   endfunction

   // Apply one accepted word to the shadow; a start queues the m*n Y elements.
   task automatic predict_word(req_word_type w);
      int m, n, k;
      logic [31:0] dot, cv, av, bv;
      bit has_c;
      y_elem_type y;
      if (w.cmd == CMD_LOAD_A) a_mem[w.idx] = w.val;
      else if (w.cmd == CMD_LOAD_B) b_mem[w.idx] = w.val;
      else if (w.cmd == CMD_LOAD_C) c_mem[w.idx] = w.val;
      else begin
         m = eff_dim(sh_m);
         n = eff_dim(sh_n);
         k = eff_dim(sh_k);
         for (int i = 0; i < m; i++) begin
            for (int j = 0; j < n; j++) begin
               dot = '0;
               for (int p = 0; p < k; p++) begin
                  av = sh_trans_a ? a_mem[p*m+i] : a_mem[i*k+p];
                  bv = sh_trans_b ? b_mem[j*k+p] : b_mem[p*n+j];
                  dot = dot + av * bv;
               end
               has_c = 1'b1;
               case (sh_c_mode)
                  CMODE_SCALAR: cv = c_mem[0];
                  CMODE_ROW:    cv = c_mem[j];
                  CMODE_COL:    cv = c_mem[i];
                  CMODE_FULL:   cv = c_mem[i*n+j];
                  default: begin
                     cv = '0;
                     has_c = 1'b0;
                  end
               endcase
               y.value = scale_q16(dot, has_c, cv);
               y.row = i[2:0];
               y.col = j[2:0];
               y.last = (i == m-1) && (j == n-1);
               expected_y.push_back(y);
            end
         end
      end
   endtask

   // Sample handshakes at the rising edge: predict, check, track registers.
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            predict_word('{cmd_type'(req_tuser), req_tdata[5:0], req_tdata[37:6]});
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TRANS_A: sh_trans_a = csr_data[0];
               REG_TRANS_B: sh_trans_b = csr_data[0];
               REG_ROWS_M:  sh_m = csr_data[3:0];
               REG_COLS_N:  sh_n = csr_data[3:0];
               REG_INNER_K: sh_k = csr_data[3:0];
               REG_ALPHA:   sh_alpha = csr_data;
               REG_BETA:    sh_beta = csr_data;
               default:     sh_c_mode = csr_data[2:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_y.size() == 0) begin
               fails++;
               $display("%0t: unexpected Y word value=%h row=%0d col=%0d last=%b", $time,
                        rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[37:35], rsp_tlast);
            end else begin
               y_elem_type e;
               e = expected_y.pop_front();
               y_checked++;
               if (rsp_tdata[31:0] !== e.value) begin
                  fails++;
                  $display("%0t: value expected %h actual %h", $time, e.value, rsp_tdata[31:0]);
               end
               if (rsp_tdata[34:32] !== e.row) begin
                  fails++;
                  $display("%0t: row expected %0d actual %0d", $time, e.row, rsp_tdata[34:32]);
               end
               if (rsp_tdata[37:35] !== e.col) begin
                  fails++;
                  $display("%0t: col expected %0d actual %0d", $time, e.col, rsp_tdata[37:35]);
               end
               if (rsp_tlast !== e.last) begin
                  fails++;
                  $display("%0t: last expected %b actual %b", $time, e.last, rsp_tlast);
               end
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d Y words outstanding", $time, expected_y.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Driver: advance to the next word once the current one is taken.
   always @(negedge clock) begin
      if (req_idle > 0) req_idle--;
      if (!reset && (!req_tvalid || req_taken)) begin
         req_taken = 1'b0;
         if (req_idle == 0 && !calm && pending_words.size() > 0 && $urandom_range(0, 9) == 0) begin
            req_idle = $urandom_range(1, 19);
            req_tvalid <= 1'b0;
         end else if (req_idle == 0 && pending_words.size() > 0) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_tuser <= w.cmd;
            req_tdata <= {2'b00, w.val, w.idx};
            req_tvalid <= 1'b1;
            words_sent++;
            if (w.cmd == CMD_START) starts_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] index, logic [31:0] data);
      @(negedge clock);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_gemm(bit ta, bit tb, logic [3:0] m, logic [3:0] n, logic [3:0] k,
                           logic [31:0] alpha, logic [31:0] beta, logic [2:0] cmode);
      csr_write(REG_TRANS_A, {31'd0, ta});
      csr_write(REG_TRANS_B, {31'd0, tb});
      csr_write(REG_ROWS_M, {28'd0, m});
      csr_write(REG_COLS_N, {28'd0, n});
      csr_write(REG_INNER_K, {28'd0, k});
      csr_write(REG_ALPHA, alpha);
      csr_write(REG_BETA, beta);
      csr_write(REG_C_MODE, {29'd0, cmode});
   endtask

   task automatic queue_word(cmd_type cmd, logic [5:0] idx, logic [31:0] val);
      req_word_type w;
      w.cmd = cmd;
      w.idx = idx;
      w.val = val;
      pending_words.push_back(w);
   endtask

   // Hold until every word is sent and every Y element is back, then settle.
   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() > 0 || req_tvalid || expected_y.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0001_0000;
         3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [3:0] rand_dim();
      case ($urandom_range(0, 9))
         0: return 4'($urandom_range(0, 15));     // out of range now and then
         1: return 4'd8;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      logic [3:0] dm, dn, dk;
      logic [2:0] cm;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Shadow registers start at their reset values.
      sh_trans_a = 1'b0;
      sh_trans_b = 1'b0;
      sh_m = 4'd8;
      sh_n = 4'd8;
      sh_k = 4'd8;
      sh_alpha = 32'h0001_0000;
      sh_beta = 32'h0001_0000;
      sh_c_mode = CMODE_NONE;

      // Fill A and B fully and the low part of C; full C is kept to m*n within it.
      for (int i = 0; i < 64; i++) begin
         queue_word(CMD_LOAD_A, i[5:0], (i == 0) ? 32'h8000_0000 : rand_elem());
         queue_word(CMD_LOAD_B, i[5:0], (i == 63) ? 32'h7FFF_FFFF : rand_elem());
         if (i < C_FILLED) queue_word(CMD_LOAD_C, i[5:0], rand_elem());
      end
      // Full 8x8x8 product on the reset settings.
      queue_word(CMD_START, 6'd63, 32'hFFFF_FFFF);
      drain();

      // Zero and oversized dimensions, both transposes, scalar C, extreme alpha.
      set_gemm(1, 1, 4'd0, 4'd15, 4'd3, 32'h7FFF_FFFF, 32'h8000_0000, CMODE_SCALAR);
      queue_word(CMD_START, 6'd0, 32'd0);
      drain();
      // Row and column vector C, undefined mode.
      set_gemm(0, 1, 4'd3, 4'd5, 4'd2, 32'h8000_0000, 32'h0001_0000, CMODE_ROW);
      queue_word(CMD_START, 6'd0, 32'd0);
      drain();
      set_gemm(1, 0, 4'd4, 4'd2, 4'd8, 32'h0000_8000, 32'h7FFF_FFFF, CMODE_COL);
      queue_word(CMD_START, 6'd0, 32'd0);
      drain();
      set_gemm(0, 0, 4'd2, 4'd2, 4'd1, 32'h0001_0000, 32'h7FFF_FFFF, 3'd7);
      queue_word(CMD_START, 6'd0, 32'd0);
      drain();
      // Wide intermediate: (-2^31)(-2^31) twice overflows 64 bits.
      set_gemm(0, 0, 4'd1, 4'd1, 4'd1, 32'h8000_0000, 32'h8000_0000, CMODE_SCALAR);
      queue_word(CMD_LOAD_A, 6'd0, 32'h8000_0000);
      queue_word(CMD_LOAD_B, 6'd0, 32'd1);
      queue_word(CMD_LOAD_C, 6'd0, 32'h8000_0000);
      queue_word(CMD_START, 6'd0, 32'd0);
      drain();

      // Random phases: new settings, a few loads and starts.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph >= 3) calm = 1'b1;
         dm = rand_dim();
         dn = rand_dim();
         dk = rand_dim();
         cm = 3'($urandom_range(0, 7));
         if (cm == CMODE_FULL && eff_dim(dm) * eff_dim(dn) > C_FILLED) cm = CMODE_COL;
         set_gemm(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dm, dn, dk,
                  rand_scale(), rand_scale(), cm);
         if (ph == 1) begin
            // Hold the receiver off while loads keep coming behind a start.
            long_hold = 400;
            queue_word(CMD_START, 6'($urandom), $urandom);
         end
         for (int w = 0; w < 2; w++) begin
            if ($urandom_range(0, 6) == 0)
               queue_word(CMD_START, 6'($urandom), $urandom);
            else
               queue_word(cmd_type'($urandom_range(0, 2)), 6'($urandom), rand_elem());
         end
         queue_word(CMD_START, 6'($urandom), $urandom);
         drain();
      end

      $display("Sent %0d request words including %0d starts; checked %0d Y elements",
               words_sent, starts_sent, y_checked);
      $display("Covered transposes, clamped dimensions, all C modes and saturation");
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/gemm_abt_pkg.sv
hdl/gemm_abt_csr.sv
hdl/gemm_abt_dp.sv
hdl/gemm_abt_ctrl.sv
hdl/gemm_alpha_beta_transpose.sv
tb/sv/tb_gemm_alpha_beta_transpose.sv
